### hdl/csvs_pkg.sv
`default_nettype none

package csvs_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned ENTRY_W    = 6;
  localparam int unsigned FIX_IN_W   = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_SET   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_UNFIXED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNSUPPORTED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN
  } csvs_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SET,
    CMD_UNSUP,
    CMD_EMPTY,
    CMD_FIRST,
    CMD_STEP,
    CMD_EXHAUST,
    CMD_VICTIM
  } csvs_cmd_e;

  typedef struct packed {
    logic is_set;
    logic bulk;
    logic n_zero;
    logic victim;
    logic last;
    logic clear_last;
  } csvs_stat_t;

endpackage

`default_nettype wire

### hdl/csvs_ctrl.sv
`default_nettype none

module csvs_ctrl import csvs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire csvs_stat_t stat_i,
  output csvs_cmd_e       cmd_o,
  output logic            busy_o
);

  csvs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    busy_o  = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_set) begin
          cmd_o   = CMD_SET;
          state_d = S_IDLE;
        end else if (stat_i.bulk) begin
          cmd_o   = CMD_UNSUP;
          state_d = S_IDLE;
        end else if (stat_i.n_zero) begin
          cmd_o   = CMD_EMPTY;
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_FIRST;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.victim) begin
          cmd_o   = CMD_VICTIM;
          state_d = S_IDLE;
        end else if (stat_i.last) begin
          cmd_o   = CMD_EXHAUST;
          state_d = S_IDLE;
        end else begin
          cmd_o = CMD_STEP;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/csvs_dp.sv
`default_nettype none

module csvs_dp import csvs_pkg::*; #(
  parameter int MAX_ENTRIES    = 64,
  parameter int FIX_COUNT_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire csvs_cmd_e             cmd_i,
  output csvs_stat_t                 stat_o,
  input  wire logic                  op_i,
  input  wire logic                  pool_i,
  input  wire logic [ENTRY_W-1:0]    entry_index_i,
  input  wire logic [FIX_IN_W-1:0]   fix_count_i,
  input  wire logic                  referenced_i,
  input  wire logic                  modified_i,
  input  wire logic                  holds_key_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ENTRY_W-1:0]         victim_index_o,
  output logic                       flush_needed_o,
  output logic                       delete_needed_o
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int DEPTH  = 2 * MAX_ENTRIES;
  localparam int AW     = $clog2(DEPTH);
  localparam int NB     = $clog2(MAX_ENTRIES + 1);
  localparam int SZ_W   = (NB > CFG_DATA_W) ? NB : CFG_DATA_W;
  localparam int CNT_W  = SZ_W + 1;
  localparam int DW     = FIX_COUNT_BITS + 3;

  // Captured item.
  logic                op_q, pool_q, ref_q, mod_q, key_q;
  logic [ENTRY_W-1:0]  idx_q;
  logic [FIX_IN_W-1:0] fix_q;

  // Configuration.
  logic [CFG_DATA_W-1:0] page_sz_q, train_sz_q;
  logic                  bulk_q;

  // Scan state.
  logic [SZ_W-1:0]  hand_q [2];
  logic [SZ_W-1:0]  v_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    clr_q;

  // Entry store and its read path.
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q, byp_q;
  logic          byp_hit_q;

  // Result registers.
  logic                done_q, flush_q, del_q;
  logic [STATUS_W-1:0] status_q;
  logic [ENTRY_W-1:0]  vic_q;

  logic [CFG_DATA_W-1:0]     cfg_n;
  logic [SZ_W-1:0]           n, hand, v0, v_inc, v_next, rpos;
  logic [CNT_W-1:0]          last_cnt;
  logic [DW-1:0]             entry, wdata;
  logic [FIX_COUNT_BITS-1:0] e_fix;
  logic                      e_ref, e_dirty, e_key, e_free;
  logic [AW-1:0]             base, waddr, raddr, scan_addr;
  logic                      we, re, set_ok, emit;

  assign cfg_n = pool_q ? train_sz_q : page_sz_q;
  assign n     = (SZ_W'(cfg_n) > SZ_W'(MAX_ENTRIES)) ? SZ_W'(MAX_ENTRIES) : SZ_W'(cfg_n);
  assign hand  = hand_q[pool_q];
  // A hand left outside a shrunk pool restarts the scan at entry zero.
  assign v0     = (hand >= n) ? '0 : hand;
  assign v_inc  = v_q + SZ_W'(1);
  assign v_next = (v_inc == n) ? '0 : v_inc;
  assign last_cnt = {n, 1'b0} - CNT_W'(1);

  // The write of the previous cycle is forwarded when it hit the address just read.
  assign entry   = byp_hit_q ? byp_q : rd_q;
  assign e_fix   = entry[DW-1:3];
  assign e_ref   = entry[2];
  assign e_dirty = entry[1];
  assign e_key   = entry[0];
  assign e_free  = (e_fix == '0);

  assign base      = pool_q ? AW'(MAX_ENTRIES) : '0;
  assign scan_addr = base + AW'(v_q[IDX_W-1:0]);
  assign rpos      = (cmd_i == CMD_FIRST) ? v0 : v_next;
  assign raddr     = base + AW'(rpos[IDX_W-1:0]);
  assign set_ok    = (32'(idx_q) < MAX_ENTRIES);

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    case (cmd_i)
      CMD_CLEAR: begin
        we = 1'b1;
      end
      CMD_SET: begin
        we    = set_ok;
        waddr = base + AW'(IDX_W'(idx_q));
        wdata = {FIX_COUNT_BITS'(fix_q), ref_q, mod_q, key_q};
      end
      CMD_STEP, CMD_EXHAUST: begin
        // An unfixed, referenced entry gets its second chance.
        we    = e_free & e_ref;
        waddr = scan_addr;
        wdata = {e_fix, 1'b0, e_dirty, e_key};
      end
      CMD_VICTIM: begin
        we    = 1'b1;
        waddr = scan_addr;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign re   = (cmd_i == CMD_FIRST) || (cmd_i == CMD_STEP);
  assign emit = (cmd_i == CMD_SET) || (cmd_i == CMD_UNSUP) || (cmd_i == CMD_EMPTY) ||
                (cmd_i == CMD_EXHAUST) || (cmd_i == CMD_VICTIM);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
    byp_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q  <= 1'b0;
      clr_q      <= '0;
      done_q     <= 1'b0;
      hand_q[0]  <= '0;
      hand_q[1]  <= '0;
      page_sz_q  <= 7'd64;
      train_sz_q <= 7'd64;
      bulk_q     <= 1'b0;
    end else begin
      byp_hit_q <= re && we && (raddr == waddr);
      done_q    <= emit;
      if (cmd_i == CMD_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i == CMD_VICTIM) begin
        hand_q[pool_q] <= v_next;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PAGE_SIZE:  page_sz_q  <= cfg_wdata_i;
          CFG_TRAIN_SIZE: train_sz_q <= cfg_wdata_i;
          CFG_BULK_FLUSH: bulk_q     <= cfg_wdata_i[0];
          default:        bulk_q     <= bulk_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      op_q   <= op_i;
      pool_q <= pool_i;
      idx_q  <= entry_index_i;
      fix_q  <= fix_count_i;
      ref_q  <= referenced_i;
      mod_q  <= modified_i;
      key_q  <= holds_key_i;
    end
    if (cmd_i == CMD_FIRST) begin
      v_q   <= v0;
      cnt_q <= '0;
    end else if (cmd_i == CMD_STEP) begin
      v_q   <= v_next;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (emit) begin
      vic_q   <= '0;
      flush_q <= 1'b0;
      del_q   <= 1'b0;
      case (cmd_i)
        CMD_SET:   status_q <= STAT_OK;
        CMD_UNSUP: status_q <= STAT_UNSUPPORTED;
        CMD_VICTIM: begin
          status_q <= STAT_OK;
          vic_q    <= v_q[ENTRY_W-1:0];
          del_q    <= e_key;
          flush_q  <= e_key & e_dirty;
        end
        default:   status_q <= STAT_NO_UNFIXED;
      endcase
    end
  end

  assign stat_o.is_set     = (op_q == OP_SET);
  assign stat_o.bulk       = bulk_q;
  assign stat_o.n_zero     = (n == '0);
  assign stat_o.victim     = e_free & ~e_ref;
  assign stat_o.last       = (cnt_q == last_cnt);
  assign stat_o.clear_last = (clr_q == AW'(DEPTH - 1));

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign victim_index_o  = vic_q;
  assign flush_needed_o  = flush_q;
  assign delete_needed_o = del_q;

endmodule

`default_nettype wire

### hdl/clock_second_chance_victim_select_top.sv
`default_nettype none

// Second-chance (clock) victim selection over a page pool and a train pool.
//
// Input channel: an input word (op, pool, entry fields) is taken at a rising edge
// where start_i is high and busy_o is low. A set-entry word loads one entry's fix
// count and marks. An allocate word scans the chosen pool from its clock hand,
// clearing reference bits of unfixed entries, and picks the first unfixed,
// unreferenced entry; that entry is cleared and the hand moves past it.
// Result channel: every word gives one result word, shown for exactly one cycle
// with done_o high. The receiver cannot stall, so results never wait.
// Set entry, bulk flush mode and an empty pool are answered from the decode state,
// through the result register to done_o. An allocate goes on to a scan that visits
// at most twice the pool size of entries (one entry per cycle through the entry
// memory's single read port). The block takes one word at a time.
// Configuration: cfg_we_i writes register cfg_idx_i at a rising edge, with no
// wait. Write it only while the block is idle.
// Reset: after rst_ni rises a clearing pass zeroes all 2*MAX_ENTRIES words of the
// entry memory; busy_o is high during the pass. Configuration returns to pool
// sizes of 64 and bulk flush off, and both clock hands go to zero.

module clock_second_chance_victim_select_top import csvs_pkg::*; #(
  parameter int MAX_ENTRIES    = 64,
  parameter int FIX_COUNT_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  op_i,
  input  wire logic                  pool_i,
  input  wire logic [ENTRY_W-1:0]    entry_index_i,
  input  wire logic [FIX_IN_W-1:0]   fix_count_i,
  input  wire logic                  referenced_i,
  input  wire logic                  modified_i,
  input  wire logic                  holds_key_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ENTRY_W-1:0]         victim_index_o,
  output logic                       flush_needed_o,
  output logic                       delete_needed_o
);

  // The controller sequences clearing, decoding and the scan; the datapath holds
  // the entry memory, the hands, configuration and the result word.
  csvs_cmd_e  cmd;
  csvs_stat_t stat;

  csvs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  csvs_dp #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .FIX_COUNT_BITS (FIX_COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (op_i),
    .pool_i          (pool_i),
    .entry_index_i   (entry_index_i),
    .fix_count_i     (fix_count_i),
    .referenced_i    (referenced_i),
    .modified_i      (modified_i),
    .holds_key_i     (holds_key_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .victim_index_o  (victim_index_o),
    .flush_needed_o  (flush_needed_o),
    .delete_needed_o (delete_needed_o)
  );

endmodule

`default_nettype wire

### hdl/csvs_checker.sv
`default_nettype none

module csvs_checker import csvs_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire logic                  busy_o,
  input wire logic                  done_o,
  input wire logic [STATUS_W-1:0]   status_o,
  input wire logic [ENTRY_W-1:0]    victim_index_o,
  input wire logic                  flush_needed_o,
  input wire logic                  delete_needed_o
);

  // A failed answer (status other than OK) carries no victim.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STAT_OK) |->
      (victim_index_o == '0) && !flush_needed_o && !delete_needed_o)
    else $error("result with error status carries victim data");

  // A flush is only requested for an entry that held a key.
  a_flush_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && flush_needed_o |-> delete_needed_o)
    else $error("flush requested without key delete");

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after accepting a word");

  // A result is shown for one cycle only, and the block is idle while it shows.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while block still busy");

endmodule

bind clock_second_chance_victim_select_top csvs_checker u_csvs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .status_o        (status_o),
  .victim_index_o  (victim_index_o),
  .flush_needed_o  (flush_needed_o),
  .delete_needed_o (delete_needed_o)
);

`default_nettype wire
